// ===== src/rasg_pkg.sv =====
// ----------------------------------------------------------------------------
// rasg_pkg
// Shared types, constants and helper functions of the random arpeggio step
// generator.
// ----------------------------------------------------------------------------
package rasg_pkg;

  // Pattern length and the width of the pattern position counter.
  localparam int PATTERN_LENGTH = 16;
  localparam int POS_W          = $clog2(PATTERN_LENGTH);
  localparam int IDX_W          = (POS_W > 4) ? POS_W : 4;

  // Results per time tick are capped at this count.
  localparam int MAX_STEPS = 12;
  localparam int CNT_W     = 4;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_PER_US  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIVISION     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_LENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEED         = 3'd4;

  // Generator constants.
  localparam logic [31:0] GEN_DEFAULT  = 32'h1234ABCD;
  localparam logic [31:0] GEN_ZERO_FIX = 32'hB16B00B5;

  // Fire thresholds: 0.82 and 0.88 of 2^32.
  localparam logic [31:0] FIRE_FREE = 32'd3521873183;
  localparam logic [31:0] FIRE_GRID = 32'd3779571221;

  // Amplitude: 0.55 + 0.45 * u in Q0.16.
  localparam logic [15:0] AMP_BASE  = 16'd36045;
  localparam logic [15:0] AMP_SCALE = 16'd29491;

  // Operation codes carried on the input side-band.
  localparam logic OP_FREE = 1'b0;
  localparam logic OP_GRID = 1'b1;

  // Control of the random word generator.
  typedef struct packed {
    logic        step;
    logic        load;
    logic [31:0] seed;
  } rng_ctrl_t;

  // Arpeggio pattern, in scale degrees.
  typedef logic [4:0] step_table_t [16];
  localparam step_table_t STEP_TABLE = '{
    5'd0, 5'd2, 5'd4, 5'd5, 5'd7, 5'd9, 5'd7, 5'd5,
    5'd4, 5'd2, 5'd5, 5'd9, 5'd12, 5'd9, 5'd7, 5'd4
  };

  // Pan per pattern index, -0.4 + 0.8 * idx / PATTERN_LENGTH in Q1.15,
  // rounded to nearest with ties away from zero.
  localparam longint PAN_DEN = 5 * PATTERN_LENGTH;
  typedef logic [14:0] pan_table_t [PATTERN_LENGTH];

  function automatic pan_table_t build_pan_table();
    pan_table_t t;
    longint     n;
    longint     r;
    for (int i = 0; i < PATTERN_LENGTH; i++) begin
      n = 64'sd32768 * (4 * longint'(i) - 2 * PATTERN_LENGTH);
      if (n >= 0) begin
        r = (2 * n + PAN_DEN) / (2 * PAN_DEN);
      end else begin
        r = -((-2 * n + PAN_DEN) / (2 * PAN_DEN));
      end
      t[i] = r[14:0];
    end
    return t;
  endfunction

  localparam pan_table_t PAN_TABLE = build_pan_table();

  // One xorshift32 step (13, 17, 5); a zero word is replaced.
  function automatic logic [31:0] xorshift_next(logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return (y == 32'd0) ? GEN_ZERO_FIX : y;
  endfunction

endpackage

// ===== src/rasg_rng.sv =====
// ----------------------------------------------------------------------------
// rasg_rng
// Xorshift32 random word generator. Steps once per request and reloads
// from the written seed on a seed write.
// ----------------------------------------------------------------------------
module rasg_rng (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rasg_pkg::rng_ctrl_t ctrl_i,
  output logic [31:0]         word_o
);

  logic [31:0] word_q;

  // A seed of zero falls back to the default word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= rasg_pkg::GEN_DEFAULT;
    end else if (ctrl_i.load) begin
      word_q <= (ctrl_i.seed == 32'd0) ? rasg_pkg::GEN_DEFAULT : ctrl_i.seed;
    end else if (ctrl_i.step) begin
      word_q <= rasg_pkg::xorshift_next(word_q);
    end
  end

  assign word_o = word_q;

endmodule

// ===== src/random_arpeggio_step_generator_unit.sv =====
// ----------------------------------------------------------------------------
// random_arpeggio_step_generator_unit
// Turns time ticks and grid step events into randomly fired arpeggio steps.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time and is not ready while it works
// on it. A time tick multiplies elapsed_us by rate_per_us in the shared
// 32x16 multiplier and, when enabled, adds the product to the step fraction,
// then gives up to 12 steps. A grid event finds grid_step modulo division
// with a one-bit-per-cycle remainder loop and gives at most one step. A
// skipped step goes through draw, fire and output; a fired step adds three
// phase draws (one generator draw per cycle) and the amplitude product.
// Each result waits for m_axis_tready. Configuration writes are taken at
// any time but must only be issued while the block is idle.
module random_arpeggio_step_generator_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [rasg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                    cfg_data_i,
  // Input stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [39:0]                    s_axis_tdata,  // elapsed_us[19:0], grid_step[35:20]
  input  logic                           s_axis_tuser,  // operation
  // Result stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // step_index[3:0], scale_position[8:4], start_phase_a[40:9],
  // start_phase_b[72:41], start_phase_c[104:73], amplitude[120:105],
  // pan[135:121]
  output logic [135:0]                   m_axis_tdata,
  output logic                           m_axis_tuser,  // fired
  output logic                           m_axis_tlast
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_MOD,
    ST_DRAW,
    ST_FIRE,
    ST_PHA,
    ST_PHB,
    ST_PHC,
    ST_AMP,
    ST_AMPADD,
    ST_OUT
  } state_e;

  // Configuration registers.
  logic        enable_q;
  logic [15:0] rate_q;
  logic [4:0]  division_q;
  logic [3:0]  scale_q;

  // Sequencer and working state.
  state_e                        state_q;
  logic                          op_q;
  logic [19:0]                   elapsed_q;
  logic [15:0]                   gsh_q;
  logic [3:0]                    bit_cnt_q;
  logic [3:0]                    rem_q;
  logic [31:0]                   frac_q;
  logic [47:0]                   prod_q;
  logic [rasg_pkg::CNT_W-1:0]    steps_left_q;
  logic [rasg_pkg::POS_W-1:0]    pos_q;

  // Result registers.
  logic        m_valid_q;
  logic        fired_q;
  logic        last_q;
  logic [3:0]  idx_out_q;
  logic [4:0]  scale_pos_q;
  logic [31:0] phase_a_q;
  logic [31:0] phase_b_q;
  logic [31:0] phase_c_q;
  logic [15:0] amp_q;
  logic [14:0] pan_q;

  logic [31:0]               word;
  rasg_pkg::rng_ctrl_t       rng_ctrl;
  logic [31:0]               mul_a;
  logic [15:0]               mul_b;
  logic [47:0]               prod_d;
  logic [36:0]               acc_d;
  logic [4:0]                steps_raw;
  logic [rasg_pkg::CNT_W-1:0] steps_sat;
  logic [4:0]                div_c;
  logic [4:0]                trial;
  logic [3:0]                rem_d;
  logic                      fire;
  logic [rasg_pkg::IDX_W-1:0] idx_ext;
  logic [3:0]                idx4;

  // Shared multiplier: rate times elapsed for ticks, draw times scale for
  // the amplitude.
  always_comb begin
    if (state_q == ST_AMP) begin
      mul_a = word;
      mul_b = rasg_pkg::AMP_SCALE;
    end else begin
      mul_a = {12'd0, elapsed_q};
      mul_b = rate_q;
    end
    prod_d = {16'd0, mul_a} * {32'd0, mul_b};
  end

  // Step fraction accumulation and whole step count, capped.
  always_comb begin
    acc_d     = {5'd0, frac_q} + prod_q[36:0];
    steps_raw = acc_d[36:32];
    steps_sat = (steps_raw > 5'(rasg_pkg::MAX_STEPS)) ?
                rasg_pkg::CNT_W'(rasg_pkg::MAX_STEPS) : steps_raw[rasg_pkg::CNT_W-1:0];
  end

  // Remainder loop: one bit of grid_step per cycle, division clamped to 1..16.
  always_comb begin
    if (division_q == 5'd0) begin
      div_c = 5'd1;
    end else if (division_q > 5'd16) begin
      div_c = 5'd16;
    end else begin
      div_c = division_q;
    end
    trial = {rem_q, gsh_q[15]};
    rem_d = (trial >= div_c) ? 4'(trial - div_c) : trial[3:0];
  end

  // Fire decision and pattern lookups.
  always_comb begin
    fire    = (op_q == rasg_pkg::OP_GRID) ? (word < rasg_pkg::FIRE_GRID)
                                          : (word < rasg_pkg::FIRE_FREE);
    idx_ext = rasg_pkg::IDX_W'(pos_q);
    idx4    = idx_ext[3:0];
  end

  // Generator control: one draw per drawing state, in the fire state only when the step fires.
  always_comb begin
    rng_ctrl.load = cfg_we_i && (cfg_idx_i == rasg_pkg::REG_SEED);
    rng_ctrl.seed = cfg_data_i;
    rng_ctrl.step = (state_q == ST_DRAW) || ((state_q == ST_FIRE) && fire) ||
                    (state_q == ST_PHA) || (state_q == ST_PHB) || (state_q == ST_PHC);
  end

  rasg_rng u_rng (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (rng_ctrl),
    .word_o (word)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      rate_q     <= 16'd6872;
      division_q <= 5'd2;
      scale_q    <= 4'd5;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rasg_pkg::REG_ENABLE:       enable_q   <= cfg_data_i[0];
        rasg_pkg::REG_RATE_PER_US:  rate_q     <= cfg_data_i[15:0];
        rasg_pkg::REG_DIVISION:     division_q <= cfg_data_i[4:0];
        rasg_pkg::REG_SCALE_LENGTH: scale_q    <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Sequencer with its working and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      m_valid_q    <= 1'b0;
      frac_q       <= 32'd0;
      pos_q        <= '0;
      steps_left_q <= '0;
      bit_cnt_q    <= 4'd0;
      rem_q        <= 4'd0;
      op_q         <= 1'b0;
      elapsed_q    <= 20'd0;
      gsh_q        <= 16'd0;
      prod_q       <= 48'd0;
      fired_q      <= 1'b0;
      last_q       <= 1'b0;
      idx_out_q    <= 4'd0;
      scale_pos_q  <= 5'd0;
      phase_a_q    <= 32'd0;
      phase_b_q    <= 32'd0;
      phase_c_q    <= 32'd0;
      amp_q        <= 16'd0;
      pan_q        <= 15'd0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            op_q      <= s_axis_tuser;
            elapsed_q <= s_axis_tdata[19:0];
            gsh_q     <= s_axis_tdata[35:20];
            rem_q     <= 4'd0;
            bit_cnt_q <= 4'd0;
            state_q   <= (s_axis_tuser == rasg_pkg::OP_GRID) ? ST_MOD : ST_MUL;
          end
        end
        ST_MUL: begin
          prod_q  <= prod_d;
          state_q <= enable_q ? ST_ACC : ST_IDLE;
        end
        ST_ACC: begin
          frac_q       <= acc_d[31:0];
          steps_left_q <= steps_sat;
          state_q      <= (steps_sat == '0) ? ST_IDLE : ST_DRAW;
        end
        ST_MOD: begin
          rem_q     <= rem_d;
          gsh_q     <= {gsh_q[14:0], 1'b0};
          bit_cnt_q <= bit_cnt_q + 4'd1;
          if (bit_cnt_q == 4'd15) begin
            if (enable_q && (rem_d == 4'd0)) begin
              steps_left_q <= rasg_pkg::CNT_W'(1);
              state_q      <= ST_DRAW;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_DRAW: begin
          state_q <= ST_FIRE;
        end
        ST_FIRE: begin
          fired_q     <= fire;
          last_q      <= (steps_left_q == rasg_pkg::CNT_W'(1));
          idx_out_q   <= idx4;
          scale_pos_q <= rasg_pkg::STEP_TABLE[idx4] + {1'b0, scale_q};
          pan_q       <= rasg_pkg::PAN_TABLE[pos_q];
          phase_a_q   <= 32'd0;
          phase_b_q   <= 32'd0;
          phase_c_q   <= 32'd0;
          amp_q       <= 16'd0;
          pos_q       <= (pos_q == rasg_pkg::POS_W'(rasg_pkg::PATTERN_LENGTH - 1)) ?
                         '0 : pos_q + rasg_pkg::POS_W'(1);
          if (fire) begin
            state_q <= ST_PHA;
          end else begin
            m_valid_q <= 1'b1;
            state_q   <= ST_OUT;
          end
        end
        ST_PHA: begin
          phase_a_q <= word;
          state_q   <= ST_PHB;
        end
        ST_PHB: begin
          phase_b_q <= word;
          state_q   <= ST_PHC;
        end
        ST_PHC: begin
          phase_c_q <= word;
          state_q   <= ST_AMP;
        end
        ST_AMP: begin
          prod_q  <= prod_d;
          state_q <= ST_AMPADD;
        end
        ST_AMPADD: begin
          amp_q     <= rasg_pkg::AMP_BASE + {1'b0, prod_q[46:32]};
          m_valid_q <= 1'b1;
          state_q   <= ST_OUT;
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            m_valid_q    <= 1'b0;
            steps_left_q <= steps_left_q - rasg_pkg::CNT_W'(1);
            state_q      <= last_q ? ST_IDLE : ST_DRAW;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Port drive.
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = fired_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = {pan_q, amp_q, phase_c_q, phase_b_q, phase_a_q,
                          scale_pos_q, idx_out_q};

endmodule

// ===== src/rasg_checker.sv =====
// ----------------------------------------------------------------------------
// rasg_checker
// Port-level checks of the random arpeggio step generator, bound to the
// top level.
// ----------------------------------------------------------------------------
module rasg_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [rasg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input logic [31:0]                    cfg_data_i,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [39:0]                    s_axis_tdata,
  input logic                           s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [135:0]                   m_axis_tdata,
  input logic                           m_axis_tuser,
  input logic                           m_axis_tlast
);

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // The block takes no new input while a result is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(m_axis_tvalid && s_axis_tready))
    else $error("input ready while a result is pending");

  // An accepted input transaction makes the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready stayed high after an accepted transaction");

  // A skipped step carries zero phases and amplitude.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[120:9] == 112'd0)
    else $error("skipped step with nonzero phase or amplitude");

  // A fired step has an amplitude of at least 0.55.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[120:105] >= rasg_pkg::AMP_BASE)
    else $error("fired step amplitude below floor");

endmodule

bind random_arpeggio_step_generator_unit rasg_checker u_rasg_checker (.*);

// ===== tb/sv/rasg_step_check.sv =====
// ----------------------------------------------------------------------------
// rasg_step_check
// Watches the channels of the random arpeggio step generator, predicts every
// arpeggio step and compares the result stream against the prediction.
// ----------------------------------------------------------------------------
// The predictor keeps its own copy of the registers, the random word, the
// pattern position and the step fraction. Each accepted input transaction
// pushes the steps it should cause, and each accepted result transaction is
// checked field by field against the oldest pending step.
module rasg_step_check (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rasg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [39:0]                    s_axis_tdata,  // elapsed_us[19:0], grid_step[35:20]
  input  logic                           s_axis_tuser,  // operation
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [135:0]                   m_axis_tdata,  // step_index, scale_position,
                                                        // phases a-c, amplitude, pan
  input  logic                           m_axis_tuser,  // fired
  input  logic                           m_axis_tlast,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Probability thresholds of 2^32 for a sounding step.
  localparam logic [31:0] TICK_FIRE_LIMIT = 32'd3521873183;
  localparam logic [31:0] GRID_FIRE_LIMIT = 32'd3779571221;
  localparam logic [31:0] SEED_FALLBACK   = 32'h1234ABCD;
  localparam logic [31:0] ZERO_WORD_SUB   = 32'hB16B00B5;
  localparam int          TICK_STEP_CAP   = 12;

  typedef struct packed {
    logic        fired;
    logic [3:0]  idx;
    logic [4:0]  scale_pos;
    logic [31:0] phase_a;
    logic [31:0] phase_b;
    logic [31:0] phase_c;
    logic [15:0] amp;
    logic [14:0] pan;
    logic        last;
  } arp_step_t;

  // Arpeggio pattern in scale degrees.
  localparam logic [4:0] ARP_DEGREES [16] = '{
    5'd0, 5'd2, 5'd4, 5'd5, 5'd7, 5'd9, 5'd7, 5'd5,
    5'd4, 5'd2, 5'd5, 5'd9, 5'd12, 5'd9, 5'd7, 5'd4
  };

  arp_step_t   step_q[$];
  int unsigned mismatches;

  // Predicted registers and state.
  logic        en_q;
  logic [15:0] rate_q;
  logic [4:0]  div_q;
  logic [3:0]  scale_q;
  logic [31:0] rng_q;
  logic [3:0]  pos_q;
  logic [31:0] frac_q;

  // Advances the xorshift word and returns the new draw.
  function automatic logic [31:0] draw_word();
    logic [31:0] x;
    x = rng_q;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    rng_q = (x == 32'd0) ? ZERO_WORD_SUB : x;
    return rng_q;
  endfunction

  // Pan of a pattern position: -0.4 + 0.8 * idx / 16 in Q1.15, ties away from zero.
  function automatic logic [14:0] pan_at(input logic [3:0] idx);
    int num;
    int den;
    int r;
    num = 32768 * (4 * int'(idx) - 32);
    den = 80;
    if (num >= 0) begin
      r = (2 * num + den) / (2 * den);
    end else begin
      r = -((-2 * num + den) / (2 * den));
    end
    return r[14:0];
  endfunction

  // Predicts one arpeggio step and queues it.
  task automatic predict_step(input logic [31:0] fire_limit, input logic is_last);
    arp_step_t   s;
    logic [31:0] d;
    logic [63:0] prod;
    s = '0;
    d = draw_word();
    s.fired     = (d < fire_limit);
    s.idx       = pos_q;
    s.scale_pos = ARP_DEGREES[pos_q] + {1'b0, scale_q};
    if (s.fired) begin
      s.phase_a = draw_word();
      s.phase_b = draw_word();
      s.phase_c = draw_word();
      prod      = 64'd29491 * {32'd0, draw_word()};
      s.amp     = 16'(32'd36045 + prod[63:32]);
    end
    s.pan  = pan_at(pos_q);
    s.last = is_last;
    step_q.push_back(s);
    pos_q = pos_q + 4'd1;
  endtask

  // Works out the steps caused by one input transaction.
  task automatic predict_item(input logic op, input logic [19:0] el, input logic [15:0] gs);
    logic [63:0] acc;
    int          n;
    int          dv;
    if (en_q) begin
      if (op == rasg_pkg::OP_FREE) begin
        if (rate_q != 16'd0) begin
          acc    = {32'd0, frac_q} + {48'd0, rate_q} * {44'd0, el};
          frac_q = acc[31:0];
          n      = (acc[63:32] > TICK_STEP_CAP) ? TICK_STEP_CAP : int'(acc[63:32]);
          for (int k = 0; k < n; k++) begin
            predict_step(TICK_FIRE_LIMIT, k == n - 1);
          end
        end
      end else begin
        dv = (div_q == 5'd0) ? 1 : (div_q > 5'd16) ? 16 : int'(div_q);
        if (int'(gs) % dv == 0) begin
          predict_step(GRID_FIRE_LIMIT, 1'b1);
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Model update, prediction and comparison at every clock edge.
  always @(posedge clk_i or negedge rst_ni) begin
    arp_step_t want;
    if (!rst_ni) begin
      en_q    = 1'b0;
      rate_q  = 16'd6872;
      div_q   = 5'd2;
      scale_q = 4'd5;
      rng_q   = SEED_FALLBACK;
      pos_q   = 4'd0;
      frac_q  = 32'd0;
      step_q.delete();
      mismatches    = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Register writes.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rasg_pkg::REG_ENABLE:       en_q    = cfg_data_i[0];
          rasg_pkg::REG_RATE_PER_US:  rate_q  = cfg_data_i[15:0];
          rasg_pkg::REG_DIVISION:     div_q   = cfg_data_i[4:0];
          rasg_pkg::REG_SCALE_LENGTH: scale_q = cfg_data_i[3:0];
          rasg_pkg::REG_SEED:
            rng_q = (cfg_data_i == 32'd0) ? SEED_FALLBACK : cfg_data_i;
          default: ;
        endcase
      end
      // Result transaction against the oldest pending step.
      if (m_axis_tvalid && m_axis_tready) begin
        if (step_q.size() == 0) begin
          $display("%0t: result mismatch, expected no result, actual tdata 0x%034h", $time,
                   m_axis_tdata);
          mismatches++;
        end else begin
          want = step_q.pop_front();
          check_field("fired", 32'(want.fired), 32'(m_axis_tuser));
          check_field("step_index", 32'(want.idx), 32'(m_axis_tdata[3:0]));
          check_field("scale_position", 32'(want.scale_pos), 32'(m_axis_tdata[8:4]));
          check_field("start_phase_a", want.phase_a, m_axis_tdata[40:9]);
          check_field("start_phase_b", want.phase_b, m_axis_tdata[72:41]);
          check_field("start_phase_c", want.phase_c, m_axis_tdata[104:73]);
          check_field("amplitude", 32'(want.amp), 32'(m_axis_tdata[120:105]));
          check_field("pan", 32'(want.pan), 32'(m_axis_tdata[135:121]));
          check_field("last", 32'(want.last), 32'(m_axis_tlast));
        end
      end
      // Input transaction.
      if (s_axis_tvalid && s_axis_tready) begin
        predict_item(s_axis_tuser, s_axis_tdata[19:0], s_axis_tdata[35:20]);
      end
      fail_count_o <= mismatches;
      pending_o    <= step_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_random_arpeggio_step_generator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_random_arpeggio_step_generator_unit
// Stimulus and verdict for the random arpeggio step generator: a directed
// part over the register and field extremes, then random phases with random
// settings, random sender gaps and random result back-pressure.
// ----------------------------------------------------------------------------
module tb_random_arpeggio_step_generator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 3000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 50;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [rasg_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [31:0]                    cfg_data_i = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [39:0]                    s_axis_tdata = '0;  // elapsed_us[19:0], grid_step[35:20]
  logic                           s_axis_tuser = 1'b0;  // operation
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [135:0]                   m_axis_tdata;  // step_index .. pan, see the block's ports
  logic                           m_axis_tuser;  // fired
  logic                           m_axis_tlast;
  int unsigned                    fail_count;
  int unsigned                    pending_steps;
  int unsigned                    quiet_cycles = 0;
  bit                             tx_idle = 1'b1;
  bit                             rx_idle = 1'b1;

  random_arpeggio_step_generator_unit u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  rasg_step_check u_step_check (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .fail_count_o(fail_count), .pending_o(pending_steps)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Ends the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: random back-pressure per result transaction.
  initial begin : rx_side
    int gap;
    forever begin
      gap = rx_idle ? $urandom_range(0, 13) : 0;
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic write_reg(input logic [rasg_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Offers one input transaction after a random gap and waits for acceptance.
  task automatic send_item(input logic op, input logic [19:0] el, input logic [15:0] gs);
    int gap;
    gap = tx_idle ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'd0, gs, el};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Holds the sender until every pending step has come out and the block settles.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_steps != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int          cur_div;
    int          cur_rate;
    int          el_max;
    logic        op;
    logic [19:0] el;
    logic [15:0] gs;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Switched off after reset: nothing comes out.
    send_item(rasg_pkg::OP_FREE, 20'd1000000, 16'd0);
    send_item(rasg_pkg::OP_GRID, 20'd0, 16'd0);
    drain();

    // Reset settings: division 2, slow rate.
    write_reg(rasg_pkg::REG_ENABLE, 32'd1);
    send_item(rasg_pkg::OP_GRID, 20'd0, 16'd0);
    send_item(rasg_pkg::OP_GRID, 20'hFFFFF, 16'd1);
    send_item(rasg_pkg::OP_GRID, 20'd0, 16'hFFFE);
    send_item(rasg_pkg::OP_FREE, 20'd0, 16'hFFFF);
    send_item(rasg_pkg::OP_FREE, 20'd1000000, 16'd0);
    send_item(rasg_pkg::OP_FREE, 20'hFFFFF, 16'd0);
    drain();

    // Fastest legal rate, then the step cap with the fraction kept.
    write_reg(rasg_pkg::REG_RATE_PER_US, 32'd51540);
    send_item(rasg_pkg::OP_FREE, 20'd1000000, 16'd0);
    send_item(rasg_pkg::OP_FREE, 20'hFFFFF, 16'd0);
    drain();

    // Full-scale rate, largest scale length, seed zero falls back to default.
    write_reg(rasg_pkg::REG_RATE_PER_US, 32'hFFFF);
    write_reg(rasg_pkg::REG_SCALE_LENGTH, 32'd15);
    write_reg(rasg_pkg::REG_SEED, 32'd0);
    send_item(rasg_pkg::OP_FREE, 20'hFFFFF, 16'hFFFF);
    send_item(rasg_pkg::OP_FREE, 20'd1, 16'd0);
    drain();

    // Rate zero halts free run; division zero acts as one.
    write_reg(rasg_pkg::REG_RATE_PER_US, 32'd0);
    write_reg(rasg_pkg::REG_DIVISION, 32'd0);
    send_item(rasg_pkg::OP_FREE, 20'hFFFFF, 16'd0);
    send_item(rasg_pkg::OP_GRID, 20'd0, 16'd3);
    drain();

    // Division above the range acts as sixteen.
    write_reg(rasg_pkg::REG_DIVISION, 32'd31);
    write_reg(rasg_pkg::REG_SCALE_LENGTH, 32'd0);
    send_item(rasg_pkg::OP_GRID, 20'd0, 16'd48);
    send_item(rasg_pkg::OP_GRID, 20'd0, 16'd17);
    drain();
    write_reg(rasg_pkg::REG_DIVISION, 32'd16);
    write_reg(rasg_pkg::REG_SEED, 32'hFFFFFFFF);
    send_item(rasg_pkg::OP_GRID, 20'd0, 16'd32);
    send_item(rasg_pkg::OP_GRID, 20'd0, 16'd40);
    drain();
    write_reg(rasg_pkg::REG_DIVISION, 32'd1);
    write_reg(rasg_pkg::REG_SCALE_LENGTH, 32'd12);
    send_item(rasg_pkg::OP_GRID, 20'd0, 16'hFFFF);
    send_item(rasg_pkg::OP_GRID, 20'hFFFFF, 16'd7);
    drain();

    // Random phases, each with its own settings and idling.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_reg(rasg_pkg::REG_ENABLE, ($urandom_range(0, 9) == 0) ? 32'd0 : 32'd1);
      case ($urandom_range(0, 7))
        0:       cur_rate = 0;
        1:       cur_rate = 51540;
        2:       cur_rate = 65535;
        3:       cur_rate = $urandom_range(1, 8000);
        default: cur_rate = $urandom_range(1, 65535);
      endcase
      write_reg(rasg_pkg::REG_RATE_PER_US, 32'(cur_rate));
      cur_div = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
      write_reg(rasg_pkg::REG_DIVISION, 32'(cur_div));
      write_reg(rasg_pkg::REG_SCALE_LENGTH, 32'($urandom_range(0, 15)));
      if ($urandom_range(0, 1) == 1) begin
        write_reg(rasg_pkg::REG_SEED, $urandom);
      end
      if (cur_div < 1) cur_div = 1;
      if (cur_div > 16) cur_div = 16;
      // Keep most ticks to a few steps so that results stay frequent.
      el_max = (cur_rate == 0) ? 20'hFFFFF :
               int'((64'd3 << 32) / 64'(cur_rate) > 64'hFFFFF ? 64'hFFFFF :
                    (64'd3 << 32) / 64'(cur_rate));
      tx_idle = ($urandom_range(0, 2) != 0);
      rx_idle = ($urandom_range(0, 2) != 0);

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        op = 1'($urandom_range(0, 1));
        el = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, el_max));
        gs = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                         : 16'($urandom_range(0, 65535 / cur_div) * cur_div);
        send_item(op, el, gs);
        // Now and then let every pending result come out before going on.
        if ($urandom_range(0, 39) == 0) begin
          drain();
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
